/* design/intcode_processor_core_assert.svh */
// Assertion macros shared by the core's checks.
`ifndef INTCODE_PROCESSOR_CORE_ASSERT_SVH
`define INTCODE_PROCESSOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ICPC_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ICPC_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* design/icpc_pkg.sv */
`timescale 1ns / 1ps

package icpc_pkg;

   // Default memory depth in words.
   localparam int MemWordsDefault = 4096;

   localparam int WordWidth   = 64;
   localparam int FieldAddrW  = 12;
   localparam int OpWidth     = 7;
   localparam int DecWidth    = 17;

   // Item function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EXEC = 1'b1;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_STEP    = 3'd0,
      ST_OUTPUT  = 3'd1,
      ST_WAIT    = 3'd2,
      ST_HALT    = 3'd3,
      ST_BAD_OP  = 3'd4,
      ST_RANGE   = 3'd5,
      ST_LOADED  = 3'd6
   } status_type;

   // Opcodes.
   localparam logic [OpWidth-1:0] OP_ADD  = 7'd1;
   localparam logic [OpWidth-1:0] OP_MUL  = 7'd2;
   localparam logic [OpWidth-1:0] OP_IN   = 7'd3;
   localparam logic [OpWidth-1:0] OP_OUT  = 7'd4;
   localparam logic [OpWidth-1:0] OP_JT   = 7'd5;
   localparam logic [OpWidth-1:0] OP_JF   = 7'd6;
   localparam logic [OpWidth-1:0] OP_LT   = 7'd7;
   localparam logic [OpWidth-1:0] OP_EQ   = 7'd8;
   localparam logic [OpWidth-1:0] OP_ARB  = 7'd9;
   localparam logic [OpWidth-1:0] OP_HALT = 7'd99;

   // Decimal reduction moduli.
   localparam logic [DecWidth-1:0] Mod100    = 17'd100;
   localparam logic [DecWidth-1:0] Mod1000   = 17'd1000;
   localparam logic [DecWidth-1:0] Mod10000  = 17'd10000;
   localparam logic [DecWidth-1:0] Mod100000 = 17'd100000;

   // Operand count of an opcode; four marks an unknown opcode.
   function automatic logic [2:0] operand_count(input logic [OpWidth-1:0] op);
      logic [2:0] n;
      case (op)
         OP_ADD, OP_MUL, OP_LT, OP_EQ: n = 3'd3;
         OP_IN, OP_OUT, OP_ARB:        n = 3'd1;
         OP_JT, OP_JF:                 n = 3'd2;
         OP_HALT:                      n = 3'd0;
         default:                      n = 3'd4;
      endcase
      return n;
   endfunction

   // Shifts one nibble into a remainder and reduces it below the modulus again.
   function automatic logic [DecWidth-1:0] reduce_nibble(input logic [DecWidth-1:0] r,
                                                         input logic [3:0] nib,
                                                         input logic [DecWidth-1:0] modulus);
      logic [DecWidth+3:0] x;
      logic [DecWidth+3:0] res;
      x   = {r, nib};
      res = x;
      for (int k = 1; k < 16; k++) begin
         if (x >= (DecWidth+4)'(k) * {4'b0000, modulus}) begin
            res = x - (DecWidth+4)'(k) * {4'b0000, modulus};
         end
      end
      return res[DecWidth-1:0];
   endfunction

endpackage

/* design/intcode_processor_core.sv */
`timescale 1ns / 1ps

// Decimal-encoded processor core with a single-port word memory.
// Request channel (req_): each item either loads one memory word (func 0) or
// executes the instruction at the program counter (func 1). Response channel
// (rsp_): exactly one item per request with a status, an output value and the
// program counter after the step.
// A load, or an instruction on a stopped core, is answered without decoding;
// halt, a bad opcode or waiting input end after decoding. Other work is one
// read for the instruction word, nibble-serial decimal decoding, up to three
// operand slot reads, two operand value reads and, for a writing opcode, a
// write-back, all through the one memory port; a multiply adds partial-product
// steps before its write-back, and a range error ends the work early. The next
// request is taken the cycle after the response is registered.
// Reset: control state clears, then a clearing pass writes zero to every
// memory word, one per cycle; req_stall stays high during that pass.
// When the receiver stalls, the response holds in the output register; one
// further request may be accepted and worked on, and its answer waits until
// the register is free.
module intcode_processor_core
   import icpc_pkg::*;
#(
   parameter int MEM_WORDS = MemWordsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [FieldAddrW-1:0]        req_load_address,
   input  logic signed [WordWidth-1:0]  req_load_value,
   input  logic signed [WordWidth-1:0]  req_input_value,
   input  logic                         req_input_valid,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic signed [WordWidth-1:0]  rsp_out_value,
   output logic [FieldAddrW-1:0]        rsp_pc_now
);

`include "intcode_processor_core_assert.svh"

   localparam int AW = $clog2(MEM_WORDS);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_WAITW, S_DEC, S_CHECK, S_OPSLOT, S_OPADDR,
      S_RDA, S_RDB, S_RDC, S_EXEC, S_MUL0, S_MUL1, S_MUL2, S_MULW, S_FINISH
   } state_type;

   state_type              state_ff;
   logic [AW-1:0]          clr_ff;
   logic [AW-1:0]          pc_ff;
   logic [WordWidth-1:0]   rel_base_ff;
   logic                   stopped_ff;
   logic [WordWidth-1:0]   ival_ff;
   logic                   ivalid_ff;
   logic [WordWidth-1:0]   sh_ff;
   logic                   sign_ff;
   logic [3:0]             cnt_ff;
   logic [DecWidth-1:0]    m2_ff, m3_ff, m4_ff, m5_ff;
   logic [OpWidth-1:0]     op_ff;
   logic [1:0]             n_ff;
   logic [1:0]             opi_ff;
   logic [3:0]             pos_ff, imm_ff;
   logic [AW-1:0]          addr_ff [4];
   logic [WordWidth-1:0]   v0_ff, v1_ff, acc_ff;
   logic [AW-1:0]          next_ff;
   status_type             st_ff;
   logic [WordWidth-1:0]   outv_ff;
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_status_ff;
   logic [WordWidth-1:0]   rsp_out_value_ff;
   logic [FieldAddrW-1:0]  rsp_pc_now_ff;

   // Memory and its port.
   logic [WordWidth-1:0]   mem [MEM_WORDS];
   logic [WordWidth-1:0]   mem_rd_ff;
   logic                   mem_we;
   logic [AW-1:0]          mem_addr;
   logic [WordWidth-1:0]   mem_wdata;

   logic                   req_acc;
   logic                   ld_ok;
   logic [AW:0]            slot_full;
   logic                   slot_bad;
   logic [WordWidth-1:0]   a_full;
   logic                   a_bad;
   logic                   take;
   logic [WordWidth-1:0]   next_full;
   logic                   next_bad;
   logic                   writes;
   logic [DecWidth-1:0]    d2, d3, d4;
   logic [OpWidth-1:0]     dec_op;
   logic [2:0]             dec_n;
   logic [31:0]            mul_a, mul_b;
   logic [WordWidth-1:0]   mul_p;

   assign req_stall     = (state_ff != S_IDLE);
   assign req_acc       = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_out_value_ff;
   assign rsp_pc_now    = rsp_pc_now_ff;

   assign ld_ok = 32'(req_load_address) < 32'(MEM_WORDS);

   // Decoded opcode and mode digits from the decimal remainders.
   assign dec_op = m2_ff[OpWidth-1:0];
   assign dec_n  = (sign_ff) ? 3'd4 : operand_count(dec_op);
   assign d2     = m3_ff - m2_ff;
   assign d3     = m4_ff - m3_ff;
   assign d4     = m5_ff - m4_ff;

   // Operand slot and operand address checks.
   assign slot_full = (AW+1)'(pc_ff) + (AW+1)'(opi_ff) + (AW+1)'(1);
   assign slot_bad  = slot_full >= (AW+1)'(MEM_WORDS);
   assign a_full    = mem_rd_ff + ((!pos_ff[opi_ff] && !imm_ff[opi_ff]) ? rel_base_ff : '0);
   assign a_bad     = a_full >= WordWidth'(MEM_WORDS);

   // Next program counter and its range check.
   always_comb begin
      take      = ((v0_ff != '0) == (op_ff == OP_JT)) && (op_ff == OP_JT || op_ff == OP_JF);
      next_full = take ? v1_ff
                       : WordWidth'((AW+2)'(pc_ff) + (AW+2)'(n_ff) + (AW+2)'(1));
      next_bad  = next_full >= WordWidth'(MEM_WORDS);
      writes    = (op_ff == OP_ADD) || (op_ff == OP_IN) || (op_ff == OP_LT) ||
                  (op_ff == OP_EQ);
   end

   // One 32 by 32 partial product per multiply cycle.
   always_comb begin
      mul_a = v0_ff[31:0];
      mul_b = v1_ff[31:0];
      case (state_ff)
         S_MUL1:  mul_b = v1_ff[63:32];
         S_MUL2:  mul_a = v0_ff[63:32];
         default: mul_a = v0_ff[31:0];
      endcase
      mul_p = WordWidth'(mul_a * mul_b);
   end

   // Memory port control.
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = pc_ff;
      mem_wdata = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
         end
         S_IDLE: begin
            if (req_acc && req_func == FUNC_LOAD && ld_ok) begin
               mem_we    = 1'b1;
               mem_addr  = AW'(req_load_address);
               mem_wdata = req_load_value;
            end
         end
         S_OPSLOT: mem_addr = slot_full[AW-1:0];
         S_RDA:    mem_addr = addr_ff[0];
         S_RDB:    mem_addr = addr_ff[1];
         S_EXEC: begin
            mem_addr = (op_ff == OP_IN) ? addr_ff[0] : addr_ff[2];
            mem_we   = writes && !next_bad;
            case (op_ff)
               OP_ADD:  mem_wdata = v0_ff + v1_ff;
               OP_IN:   mem_wdata = ival_ff;
               OP_LT:   mem_wdata = WordWidth'($signed(v0_ff) < $signed(v1_ff));
               OP_EQ:   mem_wdata = WordWidth'(v0_ff == v1_ff);
               default: mem_wdata = '0;
            endcase
         end
         S_MULW: begin
            mem_we    = 1'b1;
            mem_addr  = addr_ff[2];
            mem_wdata = acc_ff;
         end
         default: mem_we = 1'b0;
      endcase
   end

   // Word memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rd_ff <= mem[mem_addr];
   end

   // Sequencer and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         rel_base_ff  <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The finishing state decides the output register itself.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(MEM_WORDS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  ival_ff   <= req_input_value;
                  ivalid_ff <= req_input_valid;
                  outv_ff   <= '0;
                  if (req_func == FUNC_LOAD) begin
                     st_ff    <= ld_ok ? ST_LOADED : ST_RANGE;
                     state_ff <= S_FINISH;
                  end else if (stopped_ff) begin
                     st_ff    <= ST_HALT;
                     state_ff <= S_FINISH;
                  end else begin
                     state_ff <= S_WAITW;
                  end
               end
            end
            S_WAITW: begin
               sh_ff    <= mem_rd_ff;
               sign_ff  <= mem_rd_ff[WordWidth-1];
               m2_ff    <= '0;
               m3_ff    <= '0;
               m4_ff    <= '0;
               m5_ff    <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DEC;
            end
            S_DEC: begin
               // One hex digit a cycle into four decimal remainders.
               m2_ff  <= reduce_nibble(m2_ff, sh_ff[63:60], Mod100);
               m3_ff  <= reduce_nibble(m3_ff, sh_ff[63:60], Mod1000);
               m4_ff  <= reduce_nibble(m4_ff, sh_ff[63:60], Mod10000);
               m5_ff  <= reduce_nibble(m5_ff, sh_ff[63:60], Mod100000);
               sh_ff  <= {sh_ff[59:0], 4'b0000};
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               op_ff  <= dec_op;
               n_ff   <= dec_n[1:0];
               opi_ff <= '0;
               pos_ff <= {1'b0, d4 == '0, d3 == '0, d2 == '0};
               imm_ff <= {1'b0, d4 == Mod10000, d3 == Mod1000, d2 == Mod100};
               if (!sign_ff && dec_op == OP_HALT) begin
                  stopped_ff <= 1'b1;
                  st_ff      <= ST_HALT;
                  state_ff   <= S_FINISH;
               end else if (dec_n == 3'd4) begin
                  stopped_ff <= 1'b1;
                  st_ff      <= ST_BAD_OP;
                  state_ff   <= S_FINISH;
               end else if (dec_op == OP_IN && !ivalid_ff) begin
                  st_ff    <= ST_WAIT;
                  state_ff <= S_FINISH;
               end else begin
                  state_ff <= S_OPSLOT;
               end
            end
            S_OPSLOT: begin
               if (opi_ff == n_ff) begin
                  state_ff <= S_RDA;
               end else if (slot_bad) begin
                  stopped_ff <= 1'b1;
                  st_ff      <= ST_RANGE;
                  state_ff   <= S_FINISH;
               end else if (imm_ff[opi_ff]) begin
                  addr_ff[opi_ff] <= slot_full[AW-1:0];
                  opi_ff          <= opi_ff + 2'd1;
               end else begin
                  state_ff <= S_OPADDR;
               end
            end
            S_OPADDR: begin
               if (a_bad) begin
                  stopped_ff <= 1'b1;
                  st_ff      <= ST_RANGE;
                  state_ff   <= S_FINISH;
               end else begin
                  addr_ff[opi_ff] <= a_full[AW-1:0];
                  opi_ff          <= opi_ff + 2'd1;
                  state_ff        <= S_OPSLOT;
               end
            end
            S_RDA: state_ff <= S_RDB;
            S_RDB: begin
               v0_ff    <= mem_rd_ff;
               state_ff <= S_RDC;
            end
            S_RDC: begin
               v1_ff    <= mem_rd_ff;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (next_bad) begin
                  stopped_ff <= 1'b1;
                  st_ff      <= ST_RANGE;
                  state_ff   <= S_FINISH;
               end else if (op_ff == OP_MUL) begin
                  next_ff  <= next_full[AW-1:0];
                  state_ff <= S_MUL0;
               end else begin
                  pc_ff    <= next_full[AW-1:0];
                  st_ff    <= ST_STEP;
                  state_ff <= S_FINISH;
                  if (op_ff == OP_OUT) begin
                     st_ff   <= ST_OUTPUT;
                     outv_ff <= v0_ff;
                  end
                  if (op_ff == OP_ARB) begin
                     rel_base_ff <= rel_base_ff + v0_ff;
                  end
               end
            end
            S_MUL0: begin
               acc_ff   <= mul_p;
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               acc_ff   <= acc_ff + {mul_p[31:0], 32'd0};
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               acc_ff   <= acc_ff + {mul_p[31:0], 32'd0};
               state_ff <= S_MULW;
            end
            S_MULW: begin
               pc_ff    <= next_ff;
               st_ff    <= ST_STEP;
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               // Hand the item over once the output register is free.
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= st_ff;
                  rsp_out_value_ff <= outv_ff;
                  rsp_pc_now_ff    <= FieldAddrW'(pc_ff);
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Checks on the sequencer.
   `ICPC_ASSERT_SAME(a_clear_stalls, state_ff == S_CLEAR, req_stall, "request taken while clearing")
   `ICPC_ASSERT_NEXT(a_finish_hands_over, state_ff == S_FINISH && !(rsp_valid_ff && rsp_stall), rsp_valid_ff, "finished item not presented")
   `ICPC_ASSERT_SAME(a_out_zero, rsp_valid_ff && rsp_status_ff != ST_OUTPUT, rsp_out_value_ff == '0, "non-output item carries a value")

endmodule
